// ----- rtl/core/dead_reckoning_pose_error_core_macros.svh -----
// Assertion macros shared by the dead-reckoning pose error core.
`ifndef DEAD_RECKONING_POSE_ERROR_CORE_MACROS_SVH
`define DEAD_RECKONING_POSE_ERROR_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define DRPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define DRPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/drpe_pkg.sv -----
// Shared constants, types and the arctangent lookup for the pose error core.
package drpe_pkg;

    localparam int DATA_W          = 32;
    localparam int ANGLE_W         = 16;
    localparam int CFG_INDEX_W     = 8;
    localparam int ATAN_TABLE_SIZE = 24;
    localparam int ATAN_IDX_W      = $clog2(ATAN_TABLE_SIZE);
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [DATA_W-1:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [DATA_W-1:0] SPEED_RESET     = 32'd19661;
    localparam logic [DATA_W-1:0] TURN_RESET      = 32'd341782626;

    localparam logic [CFG_INDEX_W-1:0] REG_LINEAR_SPEED = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_RATE    = 8'd1;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] cos_q30;
        logic signed [DATA_W-1:0] sin_q30;
    } t_cordic_out;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] root;
    } t_sqrt_out;

    // Arctangent of 2^-idx as a 32-bit binary angle.
    function automatic logic [DATA_W-1:0] atan_angle(input logic [ATAN_IDX_W-1:0] idx);
        logic [DATA_W-1:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/core/drpe_mul.sv -----
// Shared unsigned 32x32 multiplier with a registered product.
module drpe_mul
    import drpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic [DATA_W-1:0]     i_a,
    input  logic [DATA_W-1:0]     i_b,
    output logic [2*DATA_W-1:0]   o_prod
);

    logic [2*DATA_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= {{DATA_W{1'b0}}, i_a} * {{DATA_W{1'b0}}, i_b};
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/drpe_cordic.sv -----
// Iterative rotation-mode CORDIC producing cosine and sine in Q1.30.
module drpe_cordic
    import drpe_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ANGLE_W-1:0] i_angle,
    output t_cordic_out        o_res
);

    localparam int NSTEPS = (CORDIC_STEPS > ATAN_TABLE_SIZE) ? ATAN_TABLE_SIZE : CORDIC_STEPS;
    localparam logic [ATAN_IDX_W-1:0] LAST_IDX = ATAN_IDX_W'(NSTEPS - 1);
    localparam int CW = DATA_W + 2;

    logic signed [CW-1:0]     r_x, r_y, n_x, n_y, xs, ys;
    logic signed [DATA_W:0]   r_z, n_z, step_angle;
    logic [ATAN_IDX_W-1:0]    r_idx;
    logic                     r_flip, r_busy, r_done;
    logic                     flip_in;
    logic [DATA_W-1:0]        z_start;

    // Angles outside a quarter turn of zero are turned by a half turn first.
    assign flip_in = i_angle[ANGLE_W-1] ^ i_angle[ANGLE_W-2];
    assign z_start = {i_angle[ANGLE_W-1] ^ flip_in, i_angle[ANGLE_W-2:0],
                      {(DATA_W-ANGLE_W){1'b0}}};

    always_comb begin
        xs = r_x >>> r_idx;
        ys = r_y >>> r_idx;
        step_angle = $signed({1'b0, atan_angle(r_idx)});
        if (!r_z[DATA_W]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - step_angle;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + step_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_idx == LAST_IDX) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CW'(CORDIC_GAIN_Q30);
            r_y    <= '0;
            r_z    <= $signed({z_start[DATA_W-1], z_start});
            r_idx  <= '0;
            r_flip <= flip_in;
        end else if (r_busy) begin
            r_z <= n_z;
            if (r_idx == LAST_IDX) begin
                r_x <= r_flip ? -n_x : n_x;
                r_y <= r_flip ? -n_y : n_y;
            end else begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_res.done    = r_done;
    assign o_res.cos_q30 = r_x[DATA_W-1:0];
    assign o_res.sin_q30 = r_y[DATA_W-1:0];

endmodule

// ----- rtl/core/drpe_sqrt.sv -----
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
module drpe_sqrt
    import drpe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [2*DATA_W-1:0] i_value,
    output t_sqrt_out           o_res
);

    localparam int VW = 2 * DATA_W;

    logic [VW-1:0] r_rem, r_res, r_place, trial;
    logic          r_busy, r_done;

    assign trial = r_res + r_place;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_place[0]) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_value;
            r_res   <= '0;
            r_place <= {2'b01, {(VW-2){1'b0}}};
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_place;
            end else begin
                r_res <= r_res >> 1;
            end
            r_place <= r_place >> 2;
        end
    end

    assign o_res.done = r_done;
    assign o_res.root = r_res[DATA_W-1:0];

endmodule

// ----- rtl/core/dead_reckoning_pose_error_core.sv -----
// Dead-reckoning pose error core: sequencer, pose state and shared datapath.
//
//  Channel | Direction | Handshake              | Payload
//  in      | sink      | i_in_valid/o_in_ready  | true_x, true_y, true_heading, sample_time
//  out     | source    | o_out_valid/i_out_ready| position_error, heading_error
//  cfg     | sink      | i_cfg_valid/o_cfg_ready| cfg_index, cfg_data
//
// One transaction's run is set mostly by the CORDIC iterations and the square root; an
// overflowing sum of squares skips the root. The block takes one item at a time and is
// ready again after the result leaves. Reset is synchronous, active low, clears the pose
// and the last timestamp, and returns the speed and turn registers to their reset values.
// A stalled result holds its value and blocks the next input.
`include "dead_reckoning_pose_error_core_macros.svh"

module dead_reckoning_pose_error_core
    import drpe_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_true_x,
    input  logic signed [DATA_W-1:0] i_true_y,
    input  logic [ANGLE_W-1:0]       i_true_heading,
    input  logic [DATA_W-1:0]        i_sample_time,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [DATA_W-1:0]        o_position_error,
    output logic signed [ANGLE_W-1:0] o_heading_error,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TRAV  = 4'd1;
    localparam logic [3:0] S_INC   = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_CWAIT = 4'd4;
    localparam logic [3:0] S_MLO   = 4'd5;
    localparam logic [3:0] S_MHI   = 4'd6;
    localparam logic [3:0] S_MADD  = 4'd7;
    localparam logic [3:0] S_MUPD  = 4'd8;
    localparam logic [3:0] S_ERR   = 4'd9;
    localparam logic [3:0] S_SQX   = 4'd10;
    localparam logic [3:0] S_SQY   = 4'd11;
    localparam logic [3:0] S_SUM   = 4'd12;
    localparam logic [3:0] S_SQRT  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    localparam int TW = 48;          // travel width
    localparam int AW = 80;          // accumulator width
    localparam int PW = 2 * DATA_W;  // product width

    logic [3:0]          r_state, n_state;
    logic [DATA_W-1:0]   r_speed, n_speed, r_turn, n_turn;
    logic [DATA_W-1:0]   r_rx, n_rx, r_ry, n_ry, r_head, n_head, r_prev, n_prev;
    logic [DATA_W-1:0]   r_tx, n_tx, r_ty, n_ty, r_step, n_step;
    logic [ANGLE_W-1:0]  r_th, n_th, r_herr, n_herr;
    logic [TW-1:0]       r_travel, n_travel;
    logic [AW-1:0]       r_acc, n_acc;
    logic                r_axis, n_axis;
    logic [DATA_W-1:0]   r_ax, n_ax, r_ay, n_ay, r_dist, n_dist;

    logic [DATA_W-1:0]   mul_a, mul_b;
    logic [PW-1:0]       prod, prod_speed, prod_turn;
    logic                cordic_start, sqrt_start;
    t_cordic_out         cordic_res;
    t_sqrt_out           sqrt_res;

    logic [DATA_W-1:0]   speed_mag, turn_mag, coef, coef_mag, pos;
    logic [TW-1:0]       travel_mag;
    logic [AW-DATA_W+1:0] delta_mag;
    logic [AW-DATA_W+2:0] delta;
    logic [AW-DATA_W+3:0] pos_sum;
    logic [DATA_W-1:0]   pos_sat;
    logic [DATA_W:0]     ex, ey;
    logic [PW:0]         sq_sum;
    logic                in_fire, cfg_fire;

    assign in_fire  = i_in_valid && o_in_ready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;

    assign speed_mag  = r_speed[DATA_W-1] ? -r_speed : r_speed;
    assign turn_mag   = r_turn[DATA_W-1] ? -r_turn : r_turn;
    assign prod_speed = r_speed[DATA_W-1] ? -prod : prod;
    assign prod_turn  = r_turn[DATA_W-1] ? -prod : prod;
    assign travel_mag = r_travel[TW-1] ? -r_travel : r_travel;
    assign coef       = r_axis ? cordic_res.sin_q30 : cordic_res.cos_q30;
    assign coef_mag   = coef[DATA_W-1] ? -coef : coef;
    assign pos        = r_axis ? r_ry : r_rx;

    // Product of travel and the Q1.30 coefficient, magnitude truncated, then signed.
    assign delta_mag = r_acc[AW-1:30];
    assign delta     = (r_travel[TW-1] ^ coef[DATA_W-1]) ? -{1'b0, delta_mag}
                                                        : {1'b0, delta_mag};
    assign pos_sum   = {{(AW-2*DATA_W+4){pos[DATA_W-1]}}, pos} + {delta[AW-DATA_W+2], delta};

    always_comb begin
        if (!pos_sum[AW-DATA_W+3] && (|pos_sum[AW-DATA_W+3:DATA_W-1])) begin
            pos_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (pos_sum[AW-DATA_W+3] && !(&pos_sum[AW-DATA_W+3:DATA_W-1])) begin
            pos_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            pos_sat = pos_sum[DATA_W-1:0];
        end
    end

    assign ex     = {r_tx[DATA_W-1], r_tx} - {r_rx[DATA_W-1], r_rx};
    assign ey     = {r_ty[DATA_W-1], r_ty} - {r_ry[DATA_W-1], r_ry};
    assign sq_sum = {1'b0, r_acc[PW-1:0]} + {1'b0, prod};

    always_comb begin
        n_state = r_state;
        n_speed = r_speed;
        n_turn  = r_turn;
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_head  = r_head;
        n_prev  = r_prev;
        n_tx    = r_tx;
        n_ty    = r_ty;
        n_th    = r_th;
        n_step  = r_step;
        n_herr  = r_herr;
        n_travel = r_travel;
        n_acc   = r_acc;
        n_axis  = r_axis;
        n_ax    = r_ax;
        n_ay    = r_ay;
        n_dist  = r_dist;
        mul_a   = '0;
        mul_b   = '0;
        cordic_start = 1'b0;
        sqrt_start   = 1'b0;

        if (cfg_fire) begin
            unique case (i_cfg_index)
                REG_LINEAR_SPEED: n_speed = i_cfg_data;
                REG_TURN_RATE:    n_turn  = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_tx   = i_true_x;
                    n_ty   = i_true_y;
                    n_th   = i_true_heading;
                    n_step = i_sample_time - r_prev;
                    n_prev = i_sample_time;
                    cordic_start = 1'b1;
                    n_state = S_TRAV;
                end
            end
            S_TRAV: begin
                mul_a = speed_mag;
                mul_b = r_step;
                n_state = S_INC;
            end
            S_INC: begin
                // Floor of the signed product over 2^16.
                n_travel = prod_speed[PW-1:16];
                mul_a = turn_mag;
                mul_b = r_step;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_head = r_head + prod_turn[47:16];
                n_state = S_CWAIT;
            end
            S_CWAIT: begin
                if (cordic_res.done) begin
                    n_axis  = 1'b0;
                    n_state = S_MLO;
                end
            end
            S_MLO: begin
                mul_a = {{(DATA_W-24){1'b0}}, travel_mag[23:0]};
                mul_b = coef_mag;
                n_state = S_MHI;
            end
            S_MHI: begin
                n_acc = {{(AW-PW){1'b0}}, prod};
                mul_a = {{(DATA_W-24){1'b0}}, travel_mag[TW-1:24]};
                mul_b = coef_mag;
                n_state = S_MADD;
            end
            S_MADD: begin
                n_acc = r_acc + {prod[AW-25:0], 24'b0};
                n_state = S_MUPD;
            end
            S_MUPD: begin
                if (r_axis) begin
                    n_ry = pos_sat;
                    n_state = S_ERR;
                end else begin
                    n_rx = pos_sat;
                    n_axis = 1'b1;
                    n_state = S_MLO;
                end
            end
            S_ERR: begin
                n_ax = ex[DATA_W] ? DATA_W'(-ex) : ex[DATA_W-1:0];
                n_ay = ey[DATA_W] ? DATA_W'(-ey) : ey[DATA_W-1:0];
                n_herr = r_th - r_head[DATA_W-1:DATA_W-ANGLE_W];
                n_state = S_SQX;
            end
            S_SQX: begin
                mul_a = r_ax;
                mul_b = r_ax;
                n_state = S_SQY;
            end
            S_SQY: begin
                n_acc = {{(AW-PW){1'b0}}, prod};
                mul_a = r_ay;
                mul_b = r_ay;
                n_state = S_SUM;
            end
            S_SUM: begin
                if (sq_sum[PW]) begin
                    n_dist  = '1;
                    n_state = S_OUT;
                end else begin
                    sqrt_start = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_res.done) begin
                    n_dist  = sqrt_res.root;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_speed <= SPEED_RESET;
            r_turn  <= TURN_RESET;
            r_rx    <= '0;
            r_ry    <= '0;
            r_head  <= '0;
            r_prev  <= '0;
        end else begin
            r_state <= n_state;
            r_speed <= n_speed;
            r_turn  <= n_turn;
            r_rx    <= n_rx;
            r_ry    <= n_ry;
            r_head  <= n_head;
            r_prev  <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tx     <= n_tx;
        r_ty     <= n_ty;
        r_th     <= n_th;
        r_step   <= n_step;
        r_herr   <= n_herr;
        r_travel <= n_travel;
        r_acc    <= n_acc;
        r_axis   <= n_axis;
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_dist   <= n_dist;
    end

    drpe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    drpe_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (r_head[DATA_W-1:DATA_W-ANGLE_W]),
        .o_res   (cordic_res)
    );

    drpe_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (sq_sum[PW-1:0]),
        .o_res   (sqrt_res)
    );

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_cfg_ready      = 1'b1;
    assign o_position_error = r_dist;
    assign o_heading_error  = r_herr;

    `DRPE_ASSERT_NOW(a_ready_excl, o_in_ready, !o_out_valid, "input ready while a result waits")
    `DRPE_ASSERT_NEXT(a_accept_busy, i_in_valid && o_in_ready, !o_in_ready && !o_out_valid, "accepted transaction did not start work")
    `DRPE_ASSERT_NEXT(a_out_idle, o_out_valid && i_out_ready, o_in_ready, "block not idle after result transaction")
    `DRPE_ASSERT_NOW(a_sqrt_state, sqrt_res.done, r_state == S_SQRT, "square root finished outside its wait state")

endmodule

// ----- sim/tb_dead_reckoning_pose_error_core.sv -----
// Self-checking testbench for the dead-reckoning pose error core.
module tb_dead_reckoning_pose_error_core;
    import drpe_pkg::*;

    localparam int CORDIC_STEPS   = 16;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = CORDIC_STEPS + 64;
    localparam int TIMEOUT_TIME   = 5_000_000;
    localparam int ARCTAN_ENTRIES = 24;

    localparam logic signed [DATA_W-1:0] SPEED_AFTER_RESET = 32'sd19661;
    localparam logic signed [DATA_W-1:0] TURN_AFTER_RESET  = 32'sd341782626;
    localparam longint                   UNIT_GAIN_Q30     = 64'sd652032874;
    localparam logic signed [DATA_W-1:0] POS_MAX           = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] POS_MIN           = 32'sh8000_0000;

    // Register indexes past the defined ones are ignored by the block.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED    = REG_TURN_RATE + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_TOP = '1;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [ANGLE_W-1:0]       heading;
        logic [DATA_W-1:0]        stamp;
    } t_pose_sample;

    typedef struct packed {
        logic [DATA_W-1:0]         distance;
        logic signed [ANGLE_W-1:0] heading_err;
    } t_pose_error;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    t_pose_sample           driven_pose = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [DATA_W-1:0]      position_error;
    logic [ANGLE_W-1:0]     heading_error;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data = '0;

    t_pose_sample pending_poses[$];
    t_pose_error  expected_errors[$];
    t_pose_sample next_pose;
    t_pose_error  seen_error;

    // Copy of the block's pose state and registers.
    logic signed [DATA_W-1:0] speed_setting;
    logic signed [DATA_W-1:0] turn_setting;
    logic signed [DATA_W-1:0] reckoned_x;
    logic signed [DATA_W-1:0] reckoned_y;
    logic [DATA_W-1:0]        reckoned_heading;
    logic [DATA_W-1:0]        last_stamp;

    int          sender_idle_pct = 36;
    int          receiver_idle_pct = 50;
    int          mismatch_count = 0;
    int          result_count = 0;
    logic [31:0] gen_stamp = '0;

    dead_reckoning_pose_error_core #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_true_x        (driven_pose.x),
        .i_true_y        (driven_pose.y),
        .i_true_heading  (driven_pose.heading),
        .i_sample_time   (driven_pose.stamp),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_position_error(position_error),
        .o_heading_error (heading_error),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint arctan_step(input int i);
        logic [31:0] a;
        case (i)
            0:       a = 32'h2000_0000;
            1:       a = 32'h12E4_051E;
            2:       a = 32'h09FB_385B;
            3:       a = 32'h0511_11D4;
            4:       a = 32'h028B_0D43;
            5:       a = 32'h0145_D7E1;
            6:       a = 32'h00A2_F61E;
            7:       a = 32'h0051_7C55;
            8:       a = 32'h0028_BE53;
            9:       a = 32'h0014_5F2F;
            10:      a = 32'h000A_2F98;
            11:      a = 32'h0005_17CC;
            12:      a = 32'h0002_8BE6;
            13:      a = 32'h0001_45F3;
            14:      a = 32'h0000_A2FA;
            15:      a = 32'h0000_517D;
            16:      a = 32'h0000_28BE;
            17:      a = 32'h0000_145F;
            18:      a = 32'h0000_0A30;
            19:      a = 32'h0000_0518;
            20:      a = 32'h0000_028C;
            21:      a = 32'h0000_0146;
            22:      a = 32'h0000_00A3;
            23:      a = 32'h0000_0051;
            default: a = 32'h0;
        endcase
        return longint'({32'h0, a});
    endfunction

    // Rotation-mode CORDIC; angles beyond a quarter turn are mirrored by a half turn.
    function automatic void heading_to_cos_sin(input logic [ANGLE_W-1:0] angle,
                                               output longint cos_q30,
                                               output longint sin_q30);
        logic [31:0] z_bits;
        logic        mirror;
        longint      xv;
        longint      yv;
        longint      zv;
        longint      xs;
        longint      ys;
        int          n;
        int          i;
        z_bits = {angle, 16'h0000};
        mirror = z_bits[31] ^ z_bits[30];
        if (mirror) begin
            z_bits[31] = ~z_bits[31];
        end
        zv = longint'($signed(z_bits));
        xv = UNIT_GAIN_Q30;
        yv = 0;
        n = (CORDIC_STEPS > ARCTAN_ENTRIES) ? ARCTAN_ENTRIES : CORDIC_STEPS;
        for (i = 0; i < n; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (zv >= 0) begin
                xv = xv - ys;
                yv = yv + xs;
                zv = zv - arctan_step(i);
            end else begin
                xv = xv + ys;
                yv = yv - xs;
                zv = zv + arctan_step(i);
            end
        end
        if (mirror) begin
            xv = -xv;
            yv = -yv;
        end
        cos_q30 = xv;
        sin_q30 = yv;
    endfunction

    // Product scaled down by 2^30 with the magnitude truncated toward zero.
    function automatic longint scale_by_q30(input longint a, input longint b);
        logic [95:0] prod;
        logic [63:0] ma;
        logic [63:0] mb;
        logic        neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        prod = {32'h0, ma} * {32'h0, mb};
        prod = prod >> 30;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_position(input longint v);
        if (v > longint'(POS_MAX)) begin
            return POS_MAX;
        end
        if (v < longint'(POS_MIN)) begin
            return POS_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] trial;
        int          b;
        r = '0;
        for (b = 31; b >= 0; b--) begin
            trial = r | (32'h1 << b);
            if ({32'h0, trial} * {32'h0, trial} <= v) begin
                r = trial;
            end
        end
        return r;
    endfunction

    function automatic t_pose_error predict_pose_error(input t_pose_sample s);
        t_pose_error e;
        logic [31:0] step_bits;
        longint      step;
        longint      travel;
        longint      c;
        longint      sn;
        longint      ex;
        longint      ey;
        logic [63:0] turn_prod;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] sq_x;
        logic [63:0] sq_y;
        logic [64:0] sum;
        step_bits = s.stamp - last_stamp;
        step = longint'({32'h0, step_bits});
        last_stamp = s.stamp;
        travel = (longint'(speed_setting) * step) >>> 16;
        heading_to_cos_sin(reckoned_heading[31:16], c, sn);
        reckoned_x = clamp_position(longint'(reckoned_x) + scale_by_q30(travel, c));
        reckoned_y = clamp_position(longint'(reckoned_y) + scale_by_q30(travel, sn));
        turn_prod = longint'(turn_setting) * step;
        reckoned_heading = reckoned_heading + turn_prod[47:16];
        ex = longint'(s.x) - longint'(reckoned_x);
        ey = longint'(s.y) - longint'(reckoned_y);
        ax = (ex < 0) ? -ex : ex;
        ay = (ey < 0) ? -ey : ey;
        sq_x = ax * ax;
        sq_y = ay * ay;
        sum = {1'b0, sq_x} + {1'b0, sq_y};
        e.distance = sum[64] ? '1 : floor_root(sum[63:0]);
        e.heading_err = s.heading - reckoned_heading[31:16];
        return e;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s is %h, expected %h", result_count, what, got, want);
        mismatch_count++;
    endtask

    // Driver: presents queued poses and predicts each accepted transaction.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            speed_setting <= SPEED_AFTER_RESET;
            turn_setting <= TURN_AFTER_RESET;
            reckoned_x <= '0;
            reckoned_y <= '0;
            reckoned_heading <= '0;
            last_stamp <= '0;
        end else begin
            if (in_valid && in_ready) begin
                expected_errors.push_back(predict_pose_error(driven_pose));
            end
            if (!in_valid || in_ready) begin
                if (pending_poses.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_pose = pending_poses.pop_front();
                    driven_pose <= next_pose;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest prediction.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_errors.size() == 0) begin
                    report_mismatch("unexpected result, position_error", position_error, '0);
                end else begin
                    seen_error = expected_errors.pop_front();
                    if (position_error !== seen_error.distance) begin
                        report_mismatch("position_error", position_error, seen_error.distance);
                    end
                    if (heading_error !== seen_error.heading_err) begin
                        report_mismatch("heading_error", {16'h0, heading_error},
                                        {16'h0, seen_error.heading_err});
                    end
                end
                result_count++;
            end
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic queue_pose(input logic [31:0] x, input logic [31:0] y,
                              input logic [15:0] heading, input logic [31:0] stamp);
        t_pose_sample s;
        s.x = x;
        s.y = y;
        s.heading = heading;
        s.stamp = stamp;
        gen_stamp = stamp;
        pending_poses.push_back(s);
    endtask

    // Mostly steadily advancing timestamps near the origin, with jumps and noise mixed in.
    task automatic queue_random_poses(input int count);
        int kind;
        int k;
        for (k = 0; k < count; k++) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                queue_pose(int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000,
                           int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000,
                           16'($urandom()), gen_stamp + $urandom_range(1, 32'h0002_0000));
            end else if (kind < 78) begin
                queue_pose($urandom(), $urandom(), 16'($urandom()),
                           gen_stamp - $urandom_range(0, 32'h0010_0000));
            end else if (kind < 85) begin
                queue_pose($urandom(), $urandom(), 16'($urandom()), gen_stamp + $urandom());
            end else if (kind < 88) begin
                queue_pose($urandom(), $urandom(), 16'($urandom()), gen_stamp);
            end else begin
                queue_pose($urandom(), $urandom(), 16'($urandom()), $urandom());
            end
        end
    endtask

    // Waits until no pose is pending or in flight, then lets the block settle. The check
    // runs on the falling edge so that every update of the rising edge has landed.
    task automatic wait_until_idle();
        @(negedge clk);
        while (pending_poses.size() != 0 || in_valid || expected_errors.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        case (index)
            REG_LINEAR_SPEED: speed_setting = value;
            REG_TURN_RATE:    turn_setting = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] speed, input logic [31:0] turn,
                             input int sender_pct, input int receiver_pct, input int count);
        wait_until_idle();
        sender_idle_pct = sender_pct;
        receiver_idle_pct = receiver_pct;
        write_register(REG_LINEAR_SPEED, speed);
        write_register(REG_TURN_RATE, turn);
        queue_random_poses(count);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values: first step is the timestamp itself, field
        // extremes, a timestamp going backwards, the top timestamp and a zero step.
        queue_pose(32'h0, 32'h0, 16'h0000, 32'h0001_0000);
        queue_pose(POS_MAX, POS_MIN, 16'hFFFF, 32'h0001_8000);
        queue_pose(POS_MIN, POS_MAX, 16'h8000, 32'h0003_0000);
        queue_pose(32'h0, 32'h0, 16'h7FFF, 32'h0002_0000);
        queue_pose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001, 32'hFFFF_FFFF);
        queue_pose(32'h1, 32'h1, 16'h4000, 32'h0000_0000);
        queue_pose(32'h0001_0000, 32'hFFFF_0000, 16'hC000, 32'h0000_0000);

        // Full speed with a long step drives the reckoned position into saturation; one of
        // the opposite corners then overflows the sum of squares.
        wait_until_idle();
        write_register(REG_LINEAR_SPEED, POS_MAX);
        write_register(REG_TURN_RATE, 32'h0);
        queue_pose(32'h0, 32'h0, 16'h0000, gen_stamp + 32'h8000_0000);
        queue_pose(POS_MIN, POS_MIN, 16'h2000, gen_stamp + 32'h1);
        queue_pose(POS_MAX, POS_MAX, 16'h6000, gen_stamp + 32'h1);
        queue_pose(POS_MIN, POS_MAX, 16'hA000, gen_stamp + 32'h1);
        queue_pose(POS_MAX, POS_MIN, 16'hE000, gen_stamp + 32'h1);

        wait_until_idle();
        write_register(REG_LINEAR_SPEED, POS_MIN);
        write_register(REG_TURN_RATE, POS_MAX);
        write_register(REG_UNUSED, 32'h0000_0000);
        write_register(REG_INDEX_TOP, 32'hFFFF_FFFF);
        queue_pose(POS_MIN, POS_MIN, 16'h0000, gen_stamp + 32'h7FFF_FFFF);
        queue_pose(POS_MAX, POS_MAX, 16'hFFFF, gen_stamp + 32'h0000_4000);
        queue_pose(32'h0, 32'h0, 16'h8000, gen_stamp - 32'h0000_0001);

        run_phase(int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                  int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000, 36, 50, 105);
        run_phase(32'h0, POS_MIN, 36, 50, 105);
        wait_until_idle();
        write_register(CFG_INDEX_W'($urandom_range(REG_UNUSED, REG_INDEX_TOP)), $urandom());
        run_phase(POS_MAX, POS_MAX, 50, 36, 105);
        run_phase(POS_MIN, $urandom(), 50, 36, 105);
        run_phase($urandom(), $urandom(), 0, 0, 105);
        run_phase(SPEED_AFTER_RESET, TURN_AFTER_RESET, 0, 0, 105);

        wait_until_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("tb_dead_reckoning_pose_error_core: PASS");
        end else begin
            $display("tb_dead_reckoning_pose_error_core: FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_TIME);
        $display("timeout with %0d results outstanding", expected_errors.size());
        $display("tb_dead_reckoning_pose_error_core: FAIL");
        $finish;
    end

endmodule
